### rtl/fbld_pkg.sv
package fbld_pkg;

   // store geometry
   localparam int COLUMNS = 128;
   localparam int PAGES   = 8;
   localparam int ROWS    = PAGES * 8;
   localparam int DEPTH   = PAGES * COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
   localparam logic [7:0] PAGE_LIM = 8'(PAGES);
   localparam logic [8:0] ROW_LIM  = 9'(ROWS);

   // action codes of the request channel
   typedef enum logic [2:0] {
      ACT_DRAW_LINE = 3'd0,
      ACT_SET_PIXEL = 3'd1,
      ACT_SET_BYTE  = 3'd2,
      ACT_CLEAR     = 3'd3,
      ACT_READ      = 3'd4
   } action_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PLOT_RD,
      ST_PLOT_WR,
      ST_READ
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_line;
      logic load_pixel;
      logic set_byte;
      logic read_issue;
      logic clear_start;
      logic clear_step;
      logic plot_read;
      logic plot_write;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic line_last;
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

   // byte address of a page and column
   function automatic logic [ADDR_W-1:0] store_addr(input logic [7:0] page,
                                                    input logic [7:0] col);
      logic [15:0] a;
      a = 16'(page) * 16'(COLUMNS) + 16'(col);
      return a[ADDR_W-1:0];
   endfunction

endpackage

### rtl/fbld_req_if.sv
interface fbld_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] x_start;
   logic [7:0] y_start;
   logic [7:0] x_end;
   logic [7:0] y_end;
   logic       ink;
   logic [7:0] byte_value;

   modport source (output valid, action, x_start, y_start, x_end, y_end, ink, byte_value,
                   input ready);
   modport sink (input valid, action, x_start, y_start, x_end, y_end, ink, byte_value,
                 output ready);
endinterface

### rtl/fbld_rsp_if.sv
interface fbld_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       address_bad;

   modport source (output valid, read_byte, address_bad, input ready);
   modport sink (input valid, read_byte, address_bad, output ready);
endinterface

### rtl/framebuffer_line_drawer.sv
// page-organized monochrome frame store with a line rasterizer
// req_chan carries one action per transfer: draw line, set pixel, set byte,
// clear store or read byte; rsp_chan carries one result per read byte only.
// req_chan.ready is high only while the controller is idle.
// set byte: written in the transfer. set pixel: transfer, byte read, byte write.
// draw line: transfer, then a byte read and a byte write per pixel, since each
// pixel is a read-modify-write on the frame store. read byte: transfer with
// store read, then result load; the result is valid from the next cycle, when
// the block is ready again.
// clear store: transfer, then one store entry written per cycle over all 1024 entries.
// after reset the block runs the same clearing pass and accepts no transfer
// until it ends.
// results sit in an output register; a stalled receiver holds it, other
// actions still proceed, and a following read waits until the register frees.
module framebuffer_line_drawer (
   input logic        clock,
   input logic        reset,
   fbld_req_if.sink   req_chan,
   fbld_rsp_if.source rsp_chan
);
   import fbld_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fbld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .cmd        (cmd),
      .status     (status)
   );

   fbld_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .x_start     (req_chan.x_start),
      .y_start     (req_chan.y_start),
      .x_end       (req_chan.x_end),
      .y_end       (req_chan.y_end),
      .ink         (req_chan.ink),
      .byte_value  (req_chan.byte_value),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .read_byte   (rsp_chan.read_byte),
      .address_bad (rsp_chan.address_bad)
   );

endmodule

### rtl/fbld_datapath.sv
module fbld_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  fbld_pkg::dp_cmd_type   cmd,
   output fbld_pkg::dp_status_type status,
   input  logic [7:0]             x_start,
   input  logic [7:0]             y_start,
   input  logic [7:0]             x_end,
   input  logic [7:0]             y_end,
   input  logic                   ink,
   input  logic [7:0]             byte_value,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             read_byte,
   output logic                   address_bad
);
   import fbld_pkg::*;

   logic [7:0] store_mem [DEPTH];
   logic [7:0] mem_rdata_ff;

   // line stepper registers
   logic              [7:0]  x_ff, y_ff, end_ff, dmaj_ff, dmin_ff;
   logic              [7:0]  x_in, y_in, end_in, dmaj_in, dmin_in;
   logic                     major_x_ff, axial_ff, x_neg_ff, y_neg_ff, ink_ff;
   logic                     major_x_in, axial_in, x_neg_in, y_neg_in;
   logic signed       [10:0] eps_ff, eps_in;

   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              bad_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_bad_ff;

   // line setup from the request fields
   logic [7:0] ex, ey, adx, ady;
   // stepping
   logic [7:0]        cur_major, next_major, cur_minor, next_minor;
   logic              maj_neg, min_neg, minor_step;
   logic signed [10:0] eps_sum;
   logic signed [11:0] two_sum;
   // memory ports
   logic              pix_ok, byte_ok, rd_en, wr_en;
   logic [ADDR_W-1:0] pix_addr, rd_addr, wr_addr;
   logic [7:0]        pix_mask, wr_data;

   // line setup: axis lines run low to high inclusive, sloped lines from the start
   always_comb begin
      ex  = cmd.load_pixel ? x_start : x_end;
      ey  = cmd.load_pixel ? y_start : y_end;
      adx = (x_start >= ex) ? (x_start - ex) : (ex - x_start);
      ady = (y_start >= ey) ? (y_start - ey) : (ey - y_start);
      x_in       = x_start;
      y_in       = y_start;
      x_neg_in   = 1'b0;
      y_neg_in   = 1'b0;
      dmin_in    = 8'd0;
      axial_in   = 1'b1;
      if (x_start == ex) begin
         major_x_in = 1'b0;
         y_in       = (y_start < ey) ? y_start : ey;
         end_in     = (y_start < ey) ? ey : y_start;
         dmaj_in    = ady;
      end else if (y_start == ey) begin
         major_x_in = 1'b1;
         x_in       = (x_start < ex) ? x_start : ex;
         end_in     = (x_start < ex) ? ex : x_start;
         dmaj_in    = adx;
      end else begin
         axial_in   = 1'b0;
         major_x_in = (adx > ady);
         x_neg_in   = (ex < x_start);
         y_neg_in   = (ey < y_start);
         end_in     = (adx > ady) ? ex : ey;
         dmaj_in    = (adx > ady) ? adx : ady;
         dmin_in    = (adx > ady) ? ady : adx;
      end
   end

   // bresenham step
   always_comb begin
      cur_major  = major_x_ff ? x_ff : y_ff;
      cur_minor  = major_x_ff ? y_ff : x_ff;
      maj_neg    = major_x_ff ? x_neg_ff : y_neg_ff;
      min_neg    = major_x_ff ? y_neg_ff : x_neg_ff;
      next_major = maj_neg ? cur_major - 8'd1 : cur_major + 8'd1;
      next_minor = min_neg ? cur_minor - 8'd1 : cur_minor + 8'd1;
      eps_sum    = eps_ff + $signed({3'b000, dmin_ff});
      two_sum    = {eps_sum, 1'b0};
      minor_step = !axial_ff && (two_sum >= $signed({4'b0000, dmaj_ff}));
      eps_in     = minor_step ? (eps_sum - $signed({3'b000, dmaj_ff})) : eps_sum;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_line || cmd.load_pixel) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         end_ff     <= end_in;
         dmaj_ff    <= dmaj_in;
         dmin_ff    <= dmin_in;
         major_x_ff <= major_x_in;
         axial_ff   <= axial_in;
         x_neg_ff   <= x_neg_in;
         y_neg_ff   <= y_neg_in;
         ink_ff     <= ink;
         eps_ff     <= '0;
      end else if (cmd.plot_write) begin
         eps_ff <= eps_in;
         if (major_x_ff) begin
            x_ff <= next_major;
            if (minor_step) y_ff <= next_minor;
         end else begin
            y_ff <= next_major;
            if (minor_step) x_ff <= next_minor;
         end
      end
   end

   // pixel addressing and range checks
   always_comb begin
      pix_ok   = ({1'b0, x_ff} < COL_LIM) && ({1'b0, y_ff} < ROW_LIM);
      pix_addr = store_addr({3'b000, y_ff[7:3]}, x_ff);
      pix_mask = 8'b0000_0001 << y_ff[2:0];
      byte_ok  = (y_start < PAGE_LIM) && ({1'b0, x_start} < COL_LIM);
   end

   // memory port selection
   always_comb begin
      rd_en   = cmd.read_issue || cmd.plot_read;
      rd_addr = cmd.read_issue ? store_addr(y_start, x_start) : pix_addr;
      wr_en   = 1'b0;
      wr_addr = pix_addr;
      wr_data = ink_ff ? (mem_rdata_ff & ~pix_mask) : (mem_rdata_ff | pix_mask);
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = 8'd0;
      end else if (cmd.set_byte) begin
         wr_en   = byte_ok;
         wr_addr = store_addr(y_start, x_start);
         wr_data = ink ? ~byte_value : byte_value;
      end else if (cmd.plot_write) begin
         wr_en   = pix_ok;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      if (rd_en) mem_rdata_ff <= store_mem[rd_addr];
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   // read result register
   always_ff @(posedge clock) begin
      if (cmd.read_issue) bad_ff <= !byte_ok;
      if (cmd.load_rsp) begin
         rsp_byte_ff <= bad_ff ? 8'd0 : mem_rdata_ff;
         rsp_bad_ff  <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign read_byte   = rsp_byte_ff;
   assign address_bad = rsp_bad_ff;

   assign status.line_last  = axial_ff ? (cur_major == end_ff) : (next_major == end_ff);
   assign status.clear_last = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

### rtl/fbld_ctrl.sv
module fbld_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [2:0]              req_action,
   output logic                    req_ready,
   output fbld_pkg::dp_cmd_type    cmd,
   input  fbld_pkg::dp_status_type status
);
   import fbld_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action_type'(req_action))
                  ACT_DRAW_LINE: state_in = ST_PLOT_RD;
                  ACT_SET_PIXEL: state_in = ST_PLOT_RD;
                  ACT_CLEAR:     state_in = ST_CLEAR;
                  ACT_READ:      state_in = ST_READ;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_PLOT_RD: state_in = ST_PLOT_WR;
         ST_PLOT_WR: begin
            state_in = status.line_last ? ST_IDLE : ST_PLOT_RD;
         end
         ST_READ: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action_type'(req_action))
                  ACT_DRAW_LINE: cmd.load_line   = 1'b1;
                  ACT_SET_PIXEL: cmd.load_pixel  = 1'b1;
                  ACT_SET_BYTE:  cmd.set_byte    = 1'b1;
                  ACT_CLEAR:     cmd.clear_start = 1'b1;
                  ACT_READ:      cmd.read_issue  = 1'b1;
                  default:       cmd = '0;
               endcase
            end
         end
         ST_CLEAR:   cmd.clear_step = 1'b1;
         ST_PLOT_RD: cmd.plot_read  = 1'b1;
         ST_PLOT_WR: cmd.plot_write = 1'b1;
         ST_READ:    cmd.load_rsp   = status.rsp_free;
         default:    cmd = '0;
      endcase
   end

   // a pixel write always follows the read of its byte
   assert property (@(posedge clock) disable iff (reset)
      cmd.plot_write |-> $past(cmd.plot_read))
      else $error("pixel write without preceding read");

   // a result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("result register overwritten");

   // the clearing sweep stops at the last entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_last) |=> (state_ff == ST_IDLE))
      else $error("clearing sweep overran");

endmodule
